// File: sv/palette_rle_sprite_decoder_macros.svh
// Assertion macros for the palette RLE sprite decoder checker.
// Used by prsd_checker; no other dependencies.
`ifndef PALETTE_RLE_SPRITE_DECODER_MACROS_SVH
`define PALETTE_RLE_SPRITE_DECODER_MACROS_SVH

// same-cycle implication
`define PRSD_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("prsd assertion failed");

// next-cycle implication
`define PRSD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("prsd assertion failed");

`endif

// File: sv/prsd_pkg.sv
// Shared types and constants of the palette RLE sprite decoder.
// No dependencies; used by all decoder modules.
`default_nettype none

package prsd_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int PIXEL_BITS     = 17;
   localparam int LENGTH_BITS    = 9;
   localparam int OFFSET_BITS    = 16;
   localparam int SIZE_BITS      = 9;
   localparam int COLOR_BITS     = 32;
   localparam int RGB_BITS       = 24;
   localparam int INDEX_BITS     = 8;

   localparam logic CMD_PALETTE = 1'b0;
   localparam logic CMD_DATA    = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TRANSPARENT_INDEX = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COMPRESSED_MODE   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRANSPARENT_COLOR = 3'd4;

   localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] start_offset;
      logic [LENGTH_BITS-1:0] run_length;
      logic                   frame_done;
      logic                   run_clipped;
      logic                   transparent;
   } run_type;

endpackage

`default_nettype wire

// File: sv/prsd_palette_ram.sv
// Palette memory: 256 x 24-bit, one write port, one registered read port.
// Depends on prsd_pkg for widths.
`default_nettype none

module prsd_palette_ram (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [prsd_pkg::INDEX_BITS-1:0]     wr_addr,
   input  wire logic [prsd_pkg::RGB_BITS-1:0]       wr_data,
   input  wire logic                                rd_en,
   input  wire logic [prsd_pkg::INDEX_BITS-1:0]     rd_addr,
   output      logic [prsd_pkg::RGB_BITS-1:0]       rd_data
);

   logic [prsd_pkg::RGB_BITS-1:0] mem [0:(1 << prsd_pkg::INDEX_BITS)-1];
   logic [prsd_pkg::RGB_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/prsd_run_ctrl.sv
// Run builder: pixel counter, pending-count flag, clipping and frame end.
// Depends on prsd_pkg for run_type and widths.
`default_nettype none

module prsd_run_ctrl (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 accept,
   input  wire logic [prsd_pkg::INDEX_BITS-1:0]      data_byte,
   input  wire logic [prsd_pkg::INDEX_BITS-1:0]      transparent_index,
   input  wire logic                                 compressed_mode,
   input  wire logic [prsd_pkg::PIXEL_BITS-1:0]      total,
   output      logic                                 run_valid,
   output      prsd_pkg::run_type                    run
);

   logic [prsd_pkg::PIXEL_BITS-1:0]  pixels_done_ff;
   logic [prsd_pkg::PIXEL_BITS-1:0]  pixels_done_in;
   logic                             count_pending_ff;
   logic                             count_pending_in;
   logic [prsd_pkg::PIXEL_BITS-1:0]  base;
   logic [prsd_pkg::PIXEL_BITS-1:0]  remaining;
   logic [prsd_pkg::PIXEL_BITS-1:0]  sum;
   logic [prsd_pkg::LENGTH_BITS-1:0] len;
   logic [prsd_pkg::LENGTH_BITS-1:0] len_cut;
   logic                             emit;
   logic                             transp;
   logic                             clipped;
   logic                             done;

   always_comb begin
      base             = (pixels_done_ff >= total) ? '0 : pixels_done_ff;
      emit             = 1'b1;
      len              = prsd_pkg::LENGTH_BITS'(1);
      transp           = 1'b0;
      count_pending_in = count_pending_ff;
      if (count_pending_ff) begin
         len              = {1'b0, data_byte} + prsd_pkg::LENGTH_BITS'(1);
         transp           = 1'b1;
         count_pending_in = 1'b0;
      end else if (data_byte == transparent_index) begin
         transp = 1'b1;
         if (compressed_mode) begin
            emit             = 1'b0;
            count_pending_in = 1'b1;
         end
      end
      remaining = total - base;
      clipped   = prsd_pkg::PIXEL_BITS'(len) > remaining;
      len_cut   = clipped ? remaining[prsd_pkg::LENGTH_BITS-1:0] : len;
      sum       = base + prsd_pkg::PIXEL_BITS'(len_cut);
      done      = sum >= total;
      pixels_done_in = base;
      if (emit) begin
         pixels_done_in = done ? '0 : sum;
         if (done) begin
            count_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixels_done_ff   <= '0;
         count_pending_ff <= 1'b0;
      end else if (accept) begin
         pixels_done_ff   <= pixels_done_in;
         count_pending_ff <= count_pending_in;
      end
   end

   assign run_valid        = emit;
   assign run.start_offset = base[prsd_pkg::OFFSET_BITS-1:0];
   assign run.run_length   = len_cut;
   assign run.frame_done   = done;
   assign run.run_clipped  = clipped;
   assign run.transparent  = transp;

endmodule

`default_nettype wire

// File: sv/palette_rle_sprite_decoder.sv
// Palette RLE sprite decoder: takes one item per cycle (palette write or
// frame byte) while req_stall is low and gives color runs. A frame byte's
// run, if any, is registered in stage 1 and then in the output register
// before it shows on rsp_. The palette sits in a synchronous RAM with one
// write and one read port, read once per frame byte. The pixel counter and
// the run-marker flag are updated in the cycle of acceptance, so a new item
// can enter every cycle and the rate is one item per clock while rsp_stall
// is low. Two runs can wait inside; req_stall rises only when both are held
// by rsp_stall. A palette write takes effect before the next item's read.
// Depends on prsd_pkg, prsd_palette_ram and prsd_run_ctrl.
`default_nettype none

module palette_rle_sprite_decoder #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write,
   input  wire logic [prsd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [prsd_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic                                   req_command,
   input  wire logic [prsd_pkg::INDEX_BITS-1:0]        req_palette_index,
   input  wire logic [prsd_pkg::RGB_BITS-1:0]          req_palette_color,
   input  wire logic [prsd_pkg::INDEX_BITS-1:0]        req_data_byte,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic [prsd_pkg::COLOR_BITS-1:0]        rsp_pixel_color,
   output      logic [prsd_pkg::OFFSET_BITS-1:0]       rsp_start_offset,
   output      logic [prsd_pkg::LENGTH_BITS-1:0]       rsp_run_length,
   output      logic                                   rsp_frame_done,
   output      logic                                   rsp_run_clipped
);

   logic [prsd_pkg::INDEX_BITS-1:0]  transparent_index_ff;
   logic                             compressed_mode_ff;
   logic [prsd_pkg::SIZE_BITS-1:0]   frame_width_ff;
   logic [prsd_pkg::SIZE_BITS-1:0]   frame_height_ff;
   logic [prsd_pkg::COLOR_BITS-1:0]  transparent_color_ff;
   logic [prsd_pkg::PIXEL_BITS-1:0]  total_ff;
   logic [prsd_pkg::PIXEL_BITS-1:0]  total_in;
   logic                             size_ok_ff;
   logic                             size_ok_in;
   logic [prsd_pkg::SIZE_BITS-1:0]   width_in;
   logic [prsd_pkg::SIZE_BITS-1:0]   height_in;

   logic                             accept;
   logic                             accept_data;
   logic                             palette_wr;
   logic                             run_valid;
   prsd_pkg::run_type                run;
   logic [prsd_pkg::RGB_BITS-1:0]    palette_rd;

   logic                             s1_valid_ff;
   prsd_pkg::run_type                s1_run_ff;
   logic                             out_valid_ff;
   logic [prsd_pkg::COLOR_BITS-1:0]  out_color_ff;
   prsd_pkg::run_type                out_run_ff;
   logic                             advance;

   // configuration
   always_comb begin
      width_in  = frame_width_ff;
      height_in = frame_height_ff;
      if (csr_write && csr_index == prsd_pkg::REG_FRAME_WIDTH) begin
         width_in = csr_data[prsd_pkg::SIZE_BITS-1:0];
      end
      if (csr_write && csr_index == prsd_pkg::REG_FRAME_HEIGHT) begin
         height_in = csr_data[prsd_pkg::SIZE_BITS-1:0];
      end
      total_in   = prsd_pkg::PIXEL_BITS'(width_in * height_in);
      size_ok_in = (width_in != '0) && (height_in != '0) &&
                   (32'(width_in) <= 32'(MAX_WIDTH)) &&
                   (32'(height_in) <= 32'(MAX_HEIGHT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         transparent_index_ff <= '0;
         compressed_mode_ff   <= 1'b1;
         frame_width_ff       <= prsd_pkg::SIZE_BITS'(1);
         frame_height_ff      <= prsd_pkg::SIZE_BITS'(1);
         transparent_color_ff <= '0;
         total_ff             <= prsd_pkg::PIXEL_BITS'(1);
         size_ok_ff           <= 1'b1;
      end else if (csr_write) begin
         frame_width_ff  <= width_in;
         frame_height_ff <= height_in;
         total_ff        <= total_in;
         size_ok_ff      <= size_ok_in;
         case (csr_index)
            prsd_pkg::REG_TRANSPARENT_INDEX:
               transparent_index_ff <= csr_data[prsd_pkg::INDEX_BITS-1:0];
            prsd_pkg::REG_COMPRESSED_MODE:
               compressed_mode_ff <= csr_data[0];
            prsd_pkg::REG_TRANSPARENT_COLOR:
               transparent_color_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // handshake
   assign advance     = !out_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign palette_wr  = accept && req_command == prsd_pkg::CMD_PALETTE;
   assign accept_data = accept && req_command == prsd_pkg::CMD_DATA && size_ok_ff;

   prsd_palette_ram u_palette (
      .clock   (clock),
      .wr_en   (palette_wr),
      .wr_addr (req_palette_index),
      .wr_data (req_palette_color),
      .rd_en   (accept_data),
      .rd_addr (req_data_byte),
      .rd_data (palette_rd)
   );

   prsd_run_ctrl u_run_ctrl (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept_data),
      .data_byte         (req_data_byte),
      .transparent_index (transparent_index_ff),
      .compressed_mode   (compressed_mode_ff),
      .total             (total_ff),
      .run_valid         (run_valid),
      .run               (run)
   );

   // stage 1: run fields wait for palette read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= accept_data && run_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_data) begin
         s1_run_ff <= run;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         out_run_ff   <= s1_run_ff;
         out_color_ff <= s1_run_ff.transparent ? transparent_color_ff
                                               : {prsd_pkg::OPAQUE_ALPHA, palette_rd};
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_color  = out_color_ff;
   assign rsp_start_offset = out_run_ff.start_offset;
   assign rsp_run_length   = out_run_ff.run_length;
   assign rsp_frame_done   = out_run_ff.frame_done;
   assign rsp_run_clipped  = out_run_ff.run_clipped;

endmodule

`default_nettype wire

// File: sv/prsd_checker.sv
// Port-level checker for the palette RLE sprite decoder, bound to the top.
// Depends on palette_rle_sprite_decoder_macros.svh and prsd_pkg.
`default_nettype none

`include "palette_rle_sprite_decoder_macros.svh"

module prsd_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [prsd_pkg::COLOR_BITS-1:0]     rsp_pixel_color,
   input wire logic [prsd_pkg::OFFSET_BITS-1:0]    rsp_start_offset,
   input wire logic [prsd_pkg::LENGTH_BITS-1:0]    rsp_run_length,
   input wire logic                                rsp_frame_done,
   input wire logic                                rsp_run_clipped
);

   `PRSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_pixel_color) && $stable(rsp_start_offset) &&
      $stable(rsp_run_length) && $stable(rsp_frame_done) && $stable(rsp_run_clipped))
   `PRSD_ASSERT_IMP(a_len_nonzero, clock, reset, rsp_valid, rsp_run_length != '0)
   `PRSD_ASSERT_IMP(a_len_max, clock, reset, rsp_valid, rsp_run_length <= 9'd256)
   `PRSD_ASSERT_IMP(a_clip_ends_frame, clock, reset, rsp_valid && rsp_run_clipped,
      rsp_frame_done)

endmodule

bind palette_rle_sprite_decoder prsd_checker u_prsd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pixel_color  (rsp_pixel_color),
   .rsp_start_offset (rsp_start_offset),
   .rsp_run_length   (rsp_run_length),
   .rsp_frame_done   (rsp_frame_done),
   .rsp_run_clipped  (rsp_run_clipped)
);

`default_nettype wire
